FILE: src/tpm_pkg.sv
// ----------------------------------------------------------------------------
// tpm_pkg: shared types, constants and the pair table of the token merger
// Word formats on both channels, queue entry op codes and kind codes.
// ----------------------------------------------------------------------------
package tpm_pkg;

   localparam int PosWidthDefault = 32;
   localparam int FieldPosW       = 32;
   localparam int KindW           = 8;
   localparam int OpW             = 2;
   localparam int QueueDepth      = 2;

   // kind codes used by the pair table and the merger
   localparam logic [KindW-1:0] KindDot         = 8'd0;
   localparam logic [KindW-1:0] KindDDot        = 8'd1;
   localparam logic [KindW-1:0] KindPlus        = 8'd2;
   localparam logic [KindW-1:0] KindPlusPlus    = 8'd3;
   localparam logic [KindW-1:0] KindEqual       = 8'd4;
   localparam logic [KindW-1:0] KindPlusEqual   = 8'd5;
   localparam logic [KindW-1:0] KindMinus       = 8'd6;
   localparam logic [KindW-1:0] KindGreater     = 8'd7;
   localparam logic [KindW-1:0] KindArrow       = 8'd8;
   localparam logic [KindW-1:0] KindMinusMinus  = 8'd9;
   localparam logic [KindW-1:0] KindMinusEqual  = 8'd10;
   localparam logic [KindW-1:0] KindAsterisk    = 8'd11;
   localparam logic [KindW-1:0] KindAstEqual    = 8'd12;
   localparam logic [KindW-1:0] KindAstOp       = 8'd13;
   localparam logic [KindW-1:0] KindSlash       = 8'd14;
   localparam logic [KindW-1:0] KindSlashEqual  = 8'd15;
   localparam logic [KindW-1:0] KindPercent     = 8'd16;
   localparam logic [KindW-1:0] KindPctEqual    = 8'd17;
   localparam logic [KindW-1:0] KindAmp         = 8'd18;
   localparam logic [KindW-1:0] KindAmpEqual    = 8'd19;
   localparam logic [KindW-1:0] KindAmpAmp      = 8'd20;
   localparam logic [KindW-1:0] KindAmpOp       = 8'd21;
   localparam logic [KindW-1:0] KindPipe        = 8'd22;
   localparam logic [KindW-1:0] KindPipeEqual   = 8'd23;
   localparam logic [KindW-1:0] KindPipePipe    = 8'd24;
   localparam logic [KindW-1:0] KindEqualBig    = 8'd25;
   localparam logic [KindW-1:0] KindEqualEqual  = 8'd26;
   localparam logic [KindW-1:0] KindExclam      = 8'd27;
   localparam logic [KindW-1:0] KindExclEqual   = 8'd28;
   localparam logic [KindW-1:0] KindDExclam     = 8'd29;
   localparam logic [KindW-1:0] KindLesser      = 8'd30;
   localparam logic [KindW-1:0] KindLsLs        = 8'd31;
   localparam logic [KindW-1:0] KindLsEqual     = 8'd32;
   localparam logic [KindW-1:0] KindLsLsEqual   = 8'd33;
   localparam logic [KindW-1:0] KindGtGt        = 8'd34;
   localparam logic [KindW-1:0] KindGtEqual     = 8'd35;
   localparam logic [KindW-1:0] KindGtGtEqual   = 8'd36;
   localparam logic [KindW-1:0] KindAtSign      = 8'd37;
   localparam logic [KindW-1:0] KindDAtSign     = 8'd38;
   localparam logic [KindW-1:0] KindColon       = 8'd39;
   localparam logic [KindW-1:0] KindAtColon     = 8'd40;
   localparam logic [KindW-1:0] KindColonColon  = 8'd41;
   localparam logic [KindW-1:0] KindColonEqual  = 8'd42;
   localparam logic [KindW-1:0] KindQmark       = 8'd43;
   localparam logic [KindW-1:0] KindDQmark      = 8'd44;
   localparam logic [KindW-1:0] KindQExclam     = 8'd45;
   localparam logic [KindW-1:0] KindQAmp        = 8'd46;
   localparam logic [KindW-1:0] KindQPipe       = 8'd47;
   localparam logic [KindW-1:0] KindString      = 8'd48;
   localparam logic [KindW-1:0] KindEndOfString = 8'd49;
   localparam logic [KindW-1:0] KindNumeric     = 8'd50;
   localparam logic [KindW-1:0] KindEob         = 8'd51;
   localparam logic [KindW-1:0] KindEof         = 8'd52;

   localparam logic ReqToken = 1'b0;
   localparam logic ReqFlush = 1'b1;

   typedef enum logic [OpW-1:0] {
      OP_TOKEN   = 2'd0,
      OP_BARRIER = 2'd1,
      OP_FLUSH   = 2'd2
   } op_type;

   typedef struct packed {
      logic                 req_type;
      logic [KindW-1:0]     token_kind;
      logic [FieldPosW-1:0] span_begin;
      logic [FieldPosW-1:0] span_end;
      logic [FieldPosW-1:0] stream_offset;
   } req_word_type;

   typedef struct packed {
      logic [KindW-1:0]     out_kind;
      logic [FieldPosW-1:0] out_begin;
      logic [FieldPosW-1:0] out_end;
      logic                 batch_last;
   } rsp_word_type;

   typedef struct packed {
      logic             hit;
      logic [KindW-1:0] kind;
   } pair_result_type;

   // merged kind for a held kind a followed by kind b
   function automatic pair_result_type pair_lookup(logic [KindW-1:0] a,
                                                   logic [KindW-1:0] b);
      pair_result_type r;
      r.hit  = 1'b1;
      r.kind = KindDot;
      case (a)
         KindDot: begin
            if (b == KindDot) r.kind = KindDDot;
            else r.hit = 1'b0;
         end
         KindPlus: begin
            if (b == KindPlus) r.kind = KindPlusPlus;
            else if (b == KindEqual) r.kind = KindPlusEqual;
            else r.hit = 1'b0;
         end
         KindMinus: begin
            if (b == KindGreater) r.kind = KindArrow;
            else if (b == KindMinus) r.kind = KindMinusMinus;
            else if (b == KindEqual) r.kind = KindMinusEqual;
            else r.hit = 1'b0;
         end
         KindAsterisk: begin
            if (b == KindEqual) r.kind = KindAstEqual;
            else if (b == KindGreater) r.kind = KindAstOp;
            else r.hit = 1'b0;
         end
         KindSlash: begin
            if (b == KindEqual) r.kind = KindSlashEqual;
            else r.hit = 1'b0;
         end
         KindPercent: begin
            if (b == KindEqual) r.kind = KindPctEqual;
            else r.hit = 1'b0;
         end
         KindAmp: begin
            if (b == KindEqual) r.kind = KindAmpEqual;
            else if (b == KindAmp) r.kind = KindAmpAmp;
            else if (b == KindGreater) r.kind = KindAmpOp;
            else r.hit = 1'b0;
         end
         KindPipe: begin
            if (b == KindEqual) r.kind = KindPipeEqual;
            else if (b == KindPipe) r.kind = KindPipePipe;
            else r.hit = 1'b0;
         end
         KindEqual: begin
            if (b == KindGreater) r.kind = KindEqualBig;
            else if (b == KindEqual) r.kind = KindEqualEqual;
            else r.hit = 1'b0;
         end
         KindExclam: begin
            if (b == KindEqual) r.kind = KindExclEqual;
            else if (b == KindExclam) r.kind = KindDExclam;
            else r.hit = 1'b0;
         end
         KindLesser: begin
            if (b == KindLesser) r.kind = KindLsLs;
            else if (b == KindEqual) r.kind = KindLsEqual;
            else r.hit = 1'b0;
         end
         KindLsLs: begin
            if (b == KindEqual) r.kind = KindLsLsEqual;
            else r.hit = 1'b0;
         end
         KindGreater: begin
            if (b == KindGreater) r.kind = KindGtGt;
            else if (b == KindEqual) r.kind = KindGtEqual;
            else r.hit = 1'b0;
         end
         KindGtGt: begin
            if (b == KindEqual) r.kind = KindGtGtEqual;
            else r.hit = 1'b0;
         end
         KindAtSign: begin
            if (b == KindAtSign) r.kind = KindDAtSign;
            else if (b == KindColon) r.kind = KindAtColon;
            else r.hit = 1'b0;
         end
         KindColon: begin
            if (b == KindColon) r.kind = KindColonColon;
            else if (b == KindEqual) r.kind = KindColonEqual;
            else r.hit = 1'b0;
         end
         KindQmark: begin
            if (b == KindQmark) r.kind = KindDQmark;
            else if (b == KindExclam) r.kind = KindQExclam;
            else if (b == KindAmp) r.kind = KindQAmp;
            else if (b == KindPipe) r.kind = KindQPipe;
            else r.hit = 1'b0;
         end
         KindString: begin
            if (b == KindEndOfString) r.kind = KindString;
            else r.hit = 1'b0;
         end
         KindNumeric: begin
            if (b == KindNumeric) r.kind = KindNumeric;
            else r.hit = 1'b0;
         end
         default: begin
            r.hit = 1'b0;
         end
      endcase
      return r;
   endfunction

endpackage

FILE: src/tpm_front.sv
// ----------------------------------------------------------------------------
// tpm_front: input side of the token merger
// Accepts request words, sorts them into token, barrier or flush and packs
// them for the queue; offsets are cut to the position width here.
// ----------------------------------------------------------------------------
module tpm_front #(
   parameter int POS_WIDTH = tpm_pkg::PosWidthDefault
) (
   input  logic                      req_valid,
   output logic                      req_stall,
   input  tpm_pkg::req_word_type     req_data,
   input  logic                      q_full,
   output logic                      q_push,
   output logic [2*POS_WIDTH+tpm_pkg::KindW+tpm_pkg::OpW-1:0] q_data
);

   localparam int WideW = (POS_WIDTH > tpm_pkg::FieldPosW) ? POS_WIDTH
                                                            : tpm_pkg::FieldPosW;

   tpm_pkg::op_type        op;
   logic [WideW-1:0]       wide_a;
   logic [WideW-1:0]       wide_b;
   logic [POS_WIDTH-1:0]   pos_a;
   logic [POS_WIDTH-1:0]   pos_b;

   always_comb begin
      if (req_data.req_type == tpm_pkg::ReqFlush) begin
         op     = tpm_pkg::OP_FLUSH;
         // flush carries the stream offset in the first position slot
         wide_a = WideW'(req_data.stream_offset);
      end else if (req_data.token_kind == tpm_pkg::KindEob ||
                   req_data.token_kind == tpm_pkg::KindEof) begin
         op     = tpm_pkg::OP_BARRIER;
         wide_a = WideW'(req_data.span_begin);
      end else begin
         op     = tpm_pkg::OP_TOKEN;
         wide_a = WideW'(req_data.span_begin);
      end
      wide_b = WideW'(req_data.span_end);
      pos_a  = wide_a[POS_WIDTH-1:0];
      pos_b  = wide_b[POS_WIDTH-1:0];
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;
   assign q_data    = {op, req_data.token_kind, pos_a, pos_b};

endmodule

FILE: src/tpm_queue.sv
// ----------------------------------------------------------------------------
// tpm_queue: short word queue between front and back
// Register based, one write and one read per cycle.
// ----------------------------------------------------------------------------
module tpm_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = tpm_pkg::QueueDepth
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic              full,
   output logic              head_valid,
   output logic [DATA_W-1:0] head_data
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              do_pop;

   assign full       = (count_ff == CntW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: src/tpm_back.sv
// ----------------------------------------------------------------------------
// tpm_back: merge engine and result register
// Holds the pending token, folds queue words into it and emits words.
// ----------------------------------------------------------------------------
module tpm_back #(
   parameter int POS_WIDTH = tpm_pkg::PosWidthDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  logic [2*POS_WIDTH+tpm_pkg::KindW+tpm_pkg::OpW-1:0] head_data,
   output logic                  head_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output tpm_pkg::rsp_word_type rsp_data
);

   localparam int KindW = tpm_pkg::KindW;
   localparam int OpW   = tpm_pkg::OpW;
   localparam int WideW = (POS_WIDTH > tpm_pkg::FieldPosW) ? POS_WIDTH
                                                            : tpm_pkg::FieldPosW;

   tpm_pkg::op_type          op;
   logic [KindW-1:0]         kind;
   logic [POS_WIDTH-1:0]     pos_a;
   logic [POS_WIDTH-1:0]     pos_b;
   tpm_pkg::pair_result_type pair;
   logic                     adjacent;
   logic                     can_out;

   logic                     held_valid_ff, held_valid_in;
   logic [KindW-1:0]         held_kind_ff, held_kind_in;
   logic [POS_WIDTH-1:0]     held_begin_ff, held_begin_in;
   logic [POS_WIDTH-1:0]     held_end_ff, held_end_in;
   logic                     any_emitted_ff, any_emitted_in;
   logic [POS_WIDTH-1:0]     last_end_ff, last_end_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   tpm_pkg::rsp_word_type    rsp_data_ff, rsp_data_in;
   logic                     emit;
   logic [POS_WIDTH-1:0]     eof_pos;
   logic [WideW-1:0]         wide_begin;
   logic [WideW-1:0]         wide_end;

   assign pos_b = head_data[POS_WIDTH-1:0];
   assign pos_a = head_data[2*POS_WIDTH-1:POS_WIDTH];
   assign kind  = head_data[2*POS_WIDTH +: KindW];
   assign op    = tpm_pkg::op_type'(head_data[2*POS_WIDTH+KindW +: OpW]);

   assign pair     = tpm_pkg::pair_lookup(held_kind_ff, kind);
   assign adjacent = (held_kind_ff == tpm_pkg::KindString) ||
                     ((held_end_ff + POS_WIDTH'(1)) == pos_a);
   assign can_out  = !rsp_valid_ff || !rsp_stall;
   assign eof_pos  = any_emitted_ff ? (last_end_ff + POS_WIDTH'(1)) : pos_a;

   always_comb begin
      held_valid_in  = held_valid_ff;
      held_kind_in   = held_kind_ff;
      held_begin_in  = held_begin_ff;
      held_end_in    = held_end_ff;
      any_emitted_in = any_emitted_ff;
      last_end_in    = last_end_ff;
      head_pop       = 1'b0;
      emit           = 1'b0;
      wide_begin     = WideW'(held_begin_ff);
      wide_end       = WideW'(held_end_ff);
      rsp_data_in    = rsp_data_ff;

      if (head_valid) begin
         case (op)
            tpm_pkg::OP_TOKEN: begin
               if (!held_valid_ff) begin
                  head_pop = 1'b1;
               end else if (adjacent && pair.hit) begin
                  head_pop = 1'b1;
               end else if (can_out) begin
                  head_pop = 1'b1;
                  emit     = 1'b1;
               end
               if (head_pop) begin
                  if (held_valid_ff && adjacent && pair.hit) begin
                     held_kind_in = pair.kind;
                     held_end_in  = pos_b;
                  end else begin
                     held_valid_in = 1'b1;
                     held_kind_in  = kind;
                     held_begin_in = pos_a;
                     held_end_in   = pos_b;
                  end
               end
            end
            tpm_pkg::OP_BARRIER: begin
               if (!held_valid_ff) begin
                  head_pop = 1'b1;
               end else if (can_out) begin
                  head_pop      = 1'b1;
                  emit          = 1'b1;
                  held_valid_in = 1'b0;
               end
            end
            tpm_pkg::OP_FLUSH: begin
               if (can_out) begin
                  if (held_valid_ff) begin
                     // pending token goes first; Eof follows once the response register is free
                     emit          = 1'b1;
                     held_valid_in = 1'b0;
                  end else begin
                     head_pop             = 1'b1;
                     wide_begin           = WideW'(eof_pos);
                     wide_end             = WideW'(eof_pos);
                     rsp_data_in.out_kind = tpm_pkg::KindEof;
                     rsp_data_in.out_begin  = wide_begin[tpm_pkg::FieldPosW-1:0];
                     rsp_data_in.out_end    = wide_end[tpm_pkg::FieldPosW-1:0];
                     rsp_data_in.batch_last = 1'b1;
                     any_emitted_in       = 1'b0;
                  end
               end
            end
            default: begin
               head_pop = 1'b1;
            end
         endcase
      end

      if (emit) begin
         rsp_data_in.out_kind   = held_kind_ff;
         rsp_data_in.out_begin  = wide_begin[tpm_pkg::FieldPosW-1:0];
         rsp_data_in.out_end    = wide_end[tpm_pkg::FieldPosW-1:0];
         rsp_data_in.batch_last = 1'b0;
         any_emitted_in         = 1'b1;
         last_end_in            = held_end_ff;
      end

      if (emit || (head_valid && op == tpm_pkg::OP_FLUSH && can_out)) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff  <= 1'b0;
         any_emitted_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         held_kind_ff   <= '0;
         held_begin_ff  <= '0;
         held_end_ff    <= '0;
         last_end_ff    <= '0;
      end else begin
         held_valid_ff  <= held_valid_in;
         any_emitted_ff <= any_emitted_in;
         rsp_valid_ff   <= rsp_valid_in;
         held_kind_ff   <= held_kind_in;
         held_begin_ff  <= held_begin_in;
         held_end_ff    <= held_end_in;
         last_end_ff    <= last_end_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: src/token_pair_merger_core.sv
// ----------------------------------------------------------------------------
// token_pair_merger_core: folds adjacent lexer tokens into compound tokens
//
// Request channel (req_valid / req_stall / req_data) takes one word per
// cycle: a token (kind, begin, end) or an end-of-batch flush. A word moves
// when valid is high and stall is low. Response channel (rsp_*) gives
// merged tokens in order; the flush closes the batch with an Eof word
// flagged batch_last.
// Throughput: one request word per cycle while the response side keeps up;
// a flush with a pending token holds the back end until it has sent both
// its words, the token and then the Eof. A token leaves when a later word
// displaces it; after that later word is taken it passes the queue register,
// then the token's word is set in the response register and moves at the
// next edge the receiver allows.
// The front end classifies words into a two-entry queue; the back end
// holds the pending token, looks up the pair table and drives a response
// register. When the receiver stalls, the response word holds, the back
// end stops only when it must emit, and req_stall rises once the queue
// is full. Reset empties the queue, drops the pending token and clears
// the batch's emitted flag.
// ----------------------------------------------------------------------------
module token_pair_merger_core #(
   parameter int POS_WIDTH = tpm_pkg::PosWidthDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  tpm_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output tpm_pkg::rsp_word_type rsp_data
);

   // queue entry: op code, kind, two positions
   localparam int EntryW = 2*POS_WIDTH + tpm_pkg::KindW + tpm_pkg::OpW;

   logic              q_full;
   logic              q_push;
   logic [EntryW-1:0] q_push_data;
   logic              q_pop;
   logic              q_head_valid;
   logic [EntryW-1:0] q_head_data;

   tpm_front #(
      .POS_WIDTH (POS_WIDTH)
   ) u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_push_data)
   );

   tpm_queue #(
      .DATA_W (EntryW),
      .DEPTH  (tpm_pkg::QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_push_data),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head_data  (q_head_data)
   );

   // merge engine; it pops a word only once that word is fully handled
   tpm_back #(
      .POS_WIDTH (POS_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head_data  (q_head_data),
      .head_pop   (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
